FILE: hw/rtl/fpr_pkg.sv
// Package for the firmware packet receiver: shared types, codes and constants.
// No dependencies.
`default_nettype none
package fpr_pkg;
    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_CONNECTED = 2'd1,
        MODE_RECEIVING = 2'd2,
        MODE_CLOSING   = 2'd3
    } link_mode_t;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_ERASE = 2'd1,
        KIND_FLASH = 2'd2
    } result_kind_t;

    typedef enum logic [1:0] {
        REG_START_COMMAND = 2'd0,
        REG_START_LENGTH  = 2'd1,
        REG_WRITE_COMMAND = 2'd2,
        REG_ACK_GROUP     = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DECIDE,
        ST_UNPACK,
        ST_GROUP,
        ST_ERASE,
        ST_ACK,
        ST_FLASH,
        ST_FINISH
    } ctrl_state_t;

    localparam int STORE_DEPTH = 32;
    localparam logic [7:0] ACK_BAD = 8'h01;

    // Controller to datapath commands
    typedef struct packed {
        logic load_byte;      // store the accepted byte in the packet buffer
        logic connect;        // connect event
        logic drop_byte;      // discard byte while idle or closing
        logic sum_clear;      // restart checksum walk
        logic sum_step;       // add one buffer byte
        logic start_accept;   // take the start packet
        logic write_check;    // evaluate write packet checks
        logic pack_step;      // pack one payload byte
        logic count_bump;     // advance packet count
        logic group_close;    // rewind or release and clear group state
        logic out_load;       // place a result in the output register
        logic idx_clear;      // reset the walk index
        logic idx_step;       // advance the walk index
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic       is_last;
        logic       active;       // connected or receiving
        logic       receiving;
        logic       walk_done;    // checksum walk reached its end
        logic       start_ok;
        logic       write_ok;     // checks passed and sequence matches
        logic       pack_done;
        logic       group_due;
        logic       group_good;
        logic       done_after;   // count equals total after closing
        logic [5:0] words_held;
    } ctrl_status_t;
endpackage
`default_nettype wire

FILE: hw/rtl/fpr_ctrl.sv
// Controller state machine for the firmware packet receiver.
// Depends on fpr_pkg; drives fpr_datapath through command and status structs.
`default_nettype none
module fpr_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 in_operation,
    input  wire logic                 out_free,
    input  wire fpr_pkg::ctrl_status_t sts,
    output fpr_pkg::ctrl_cmd_t        cmd,
    output fpr_pkg::result_kind_t     out_kind,
    output logic [2:0]                ack_pos,
    output logic                      out_last,
    output logic                      out_from_start
);
    fpr_pkg::ctrl_state_t state_reg, state_next;
    logic [2:0] pos_reg, pos_next;
    logic       start_reg, start_next;

    // Sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fpr_pkg::ST_IDLE;
            pos_reg   <= 3'd0;
            start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        unique case (state_reg)
            fpr_pkg::ST_IDLE: begin
                if (s_valid && in_operation && sts.active && sts.is_last) begin
                    state_next = fpr_pkg::ST_CHECK;
                    start_next = !sts.receiving;
                end
            end
            fpr_pkg::ST_CHECK: begin
                if (sts.walk_done) state_next = fpr_pkg::ST_DECIDE;
            end
            fpr_pkg::ST_DECIDE: begin
                pos_next = 3'd0;
                if (start_reg) begin
                    state_next = sts.start_ok ? fpr_pkg::ST_ERASE : fpr_pkg::ST_ACK;
                end else begin
                    state_next = sts.write_ok ? fpr_pkg::ST_UNPACK : fpr_pkg::ST_GROUP;
                end
            end
            fpr_pkg::ST_UNPACK: begin
                if (sts.pack_done) state_next = fpr_pkg::ST_GROUP;
            end
            fpr_pkg::ST_GROUP: begin
                state_next = sts.group_due ? fpr_pkg::ST_ACK : fpr_pkg::ST_IDLE;
            end
            fpr_pkg::ST_ERASE: begin
                if (out_free) state_next = fpr_pkg::ST_ACK;
            end
            fpr_pkg::ST_ACK: begin
                if (out_free) begin
                    pos_next = pos_reg + 3'd1;
                    if (pos_reg == 3'd4) begin
                        pos_next = 3'd0;
                        if (start_reg) state_next = fpr_pkg::ST_IDLE;
                        else           state_next = fpr_pkg::ST_FLASH;
                    end
                end
            end
            fpr_pkg::ST_FLASH: begin
                if (!sts.group_good || sts.words_held == 6'd0) begin
                    state_next = fpr_pkg::ST_FINISH;
                end else if (out_free && sts.pack_done) begin
                    state_next = fpr_pkg::ST_FINISH;
                end
            end
            fpr_pkg::ST_FINISH: state_next = fpr_pkg::ST_IDLE;
            default: state_next = fpr_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd            = '0;
        s_ready        = 1'b0;
        out_kind       = fpr_pkg::KIND_ACK;
        ack_pos        = pos_reg;
        out_last       = 1'b0;
        out_from_start = start_reg;
        unique case (state_reg)
            fpr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (!in_operation) cmd.connect = 1'b1;
                    else if (!sts.active) cmd.drop_byte = 1'b1;
                    else cmd.load_byte = 1'b1;
                    cmd.sum_clear = 1'b1;
                    cmd.idx_clear = 1'b1;
                end
            end
            fpr_pkg::ST_CHECK: begin
                cmd.sum_step = 1'b1;
                cmd.idx_step = 1'b1;
            end
            fpr_pkg::ST_DECIDE: begin
                cmd.idx_clear = 1'b1;
                if (start_reg) cmd.start_accept = sts.start_ok;
                else cmd.write_check = 1'b1;
            end
            fpr_pkg::ST_UNPACK: begin
                cmd.pack_step = 1'b1;
                cmd.idx_step  = 1'b1;
            end
            fpr_pkg::ST_GROUP: begin
                cmd.count_bump = 1'b1;
                cmd.idx_clear  = 1'b1;
            end
            fpr_pkg::ST_ERASE: begin
                out_kind     = fpr_pkg::KIND_ERASE;
                cmd.out_load = out_free;
            end
            fpr_pkg::ST_ACK: begin
                out_kind     = fpr_pkg::KIND_ACK;
                cmd.out_load = out_free;
                out_last     = (pos_reg == 3'd4) &&
                               (start_reg || !sts.group_good || sts.words_held == 6'd0);
            end
            fpr_pkg::ST_FLASH: begin
                out_kind = fpr_pkg::KIND_FLASH;
                if (sts.group_good && sts.words_held != 6'd0) begin
                    cmd.out_load = out_free;
                    cmd.idx_step = out_free;
                    out_last     = sts.pack_done;
                end
            end
            fpr_pkg::ST_FINISH: cmd.group_close = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: hw/rtl/fpr_datapath.sv
// Datapath of the firmware packet receiver: packet buffer, checksum walk,
// word packing, counters and the output register. Depends on fpr_pkg.
`default_nettype none
module fpr_datapath #(
    parameter int PACKET_MAX_BYTES = 20,
    parameter int PAYLOAD_BYTES    = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_write,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [7:0]            cfg_data,
    input  wire logic [7:0]            in_data_byte,
    input  wire logic                  in_last_byte,
    input  wire fpr_pkg::ctrl_cmd_t    cmd,
    input  wire fpr_pkg::result_kind_t out_kind_in,
    input  wire logic [2:0]            ack_pos,
    input  wire logic                  out_last_in,
    input  wire logic                  out_from_start,
    output fpr_pkg::ctrl_status_t      sts,
    output logic                       out_free,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_kind,
    output logic [63:0]                m_value,
    output logic [4:0]                 m_word_number,
    output logic                       m_transfer_done,
    output logic                       m_last_of_run
);
    localparam int LW = $clog2(PACKET_MAX_BYTES + 2);
    localparam int BW = $clog2(PACKET_MAX_BYTES);
    localparam logic [LW-1:0] MAXL = LW'(PACKET_MAX_BYTES);

    logic [7:0] start_command_reg, write_command_reg;
    logic [4:0] start_length_reg, ack_group_reg;
    fpr_pkg::link_mode_t mode_reg, mode_next;
    logic [7:0] buf_reg [PACKET_MAX_BYTES];
    logic [LW-1:0] len_reg, len_next, n_reg;
    logic [15:0] total_reg, count_reg, count_next;
    logic group_ok_reg, group_ok_next;
    logic [5:0] held_reg, held_next;
    logic [2:0] bpos_reg, bpos_next;
    logic [LW-1:0] idx_reg;
    logic [7:0] sum_reg;
    logic [4:0] grp_reg, grp_next;   // count modulo group
    logic m_valid_reg;
    logic [1:0] m_kind_reg;
    logic [63:0] m_value_reg;
    logic [4:0] m_word_reg;
    logic m_done_reg, m_last_reg;
    logic [63:0] word_rd;
    logic [4:0] g;
    logic [7:0] hi, lo;
    logic [7:0] bsel, ack_byte;
    logic [5:0] wr_addr;
    logic wr_en;
    logic [63:0] wr_data, acc_reg;

    assign g  = (ack_group_reg == 5'd0) ? 5'd1 : ack_group_reg;
    assign hi = count_reg[15:8];
    assign lo = count_reg[7:0];
    assign bsel = (idx_reg < MAXL) ? buf_reg[idx_reg[BW-1:0]] : 8'd0;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_command_reg <= 8'd0;
            start_length_reg  <= 5'd4;
            write_command_reg <= 8'd1;
            ack_group_reg     <= 5'd16;
        end else if (cfg_write) begin
            unique case (fpr_pkg::reg_index_t'(cfg_index))
                fpr_pkg::REG_START_COMMAND: start_command_reg <= cfg_data;
                fpr_pkg::REG_START_LENGTH:  start_length_reg  <= cfg_data[4:0];
                fpr_pkg::REG_WRITE_COMMAND: write_command_reg <= cfg_data;
                fpr_pkg::REG_ACK_GROUP:     ack_group_reg     <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Packet buffer write
    always_ff @(posedge aclk) begin
        if (cmd.load_byte && len_reg < MAXL) buf_reg[len_reg[BW-1:0]] <= in_data_byte;
    end

    // Checksum walk: bytes 1 (start) or 3 (write) up to n-2
    logic [LW-1:0] sum_first;
    logic walk_in;
    assign sum_first = out_from_start ? LW'(1) : LW'(3);
    assign walk_in = (idx_reg >= sum_first) && (idx_reg + LW'(2) <= n_reg) &&
                     (idx_reg < MAXL);
    always_ff @(posedge aclk) begin
        if (cmd.sum_clear) sum_reg <= 8'd0;
        else if (cmd.sum_step && walk_in) sum_reg <= sum_reg + bsel;
    end

    always_ff @(posedge aclk) begin
        if (cmd.idx_clear) idx_reg <= (cmd.write_check ? LW'(3) : '0);
        else if (cmd.idx_step) idx_reg <= idx_reg + LW'(1);
    end

    // Checks
    logic n_ok, last_ok;
    logic [7:0] last_b;
    assign last_b  = buf_reg[BW'(n_reg - LW'(1))];
    assign n_ok    = (n_reg >= LW'(4)) && (n_reg <= MAXL);
    assign last_ok = n_ok && (sum_reg == last_b);
    assign sts.start_ok = last_ok && (n_reg == LW'(start_length_reg)) &&
                          (buf_reg[0] == start_command_reg);
    logic wr_pass;
    assign wr_pass = last_ok && (32'(n_reg) - 32'd4 <= 32'(PAYLOAD_BYTES)) &&
                     (buf_reg[0] == write_command_reg);
    assign sts.write_ok = wr_pass && ({buf_reg[1], buf_reg[2]} == count_reg);
    assign sts.walk_done = (idx_reg == MAXL);

    // Packing into the word store
    logic pack_live;
    assign pack_live = cmd.pack_step && (idx_reg + LW'(1) < n_reg);
    always_comb begin
        wr_en = 1'b0; wr_addr = held_reg; wr_data = acc_reg;
        held_next = held_reg; bpos_next = bpos_reg;
        if (pack_live) begin
            if (bpos_reg == 3'd0) begin
                if (held_reg < 6'(fpr_pkg::STORE_DEPTH)) begin
                    wr_en = 1'b1; wr_addr = held_reg; wr_data = {56'd0, bsel};
                    held_next = held_reg + 6'd1; bpos_next = 3'd1;
                end
            end else begin
                wr_en = 1'b1; wr_addr = held_reg - 6'd1;
                wr_data = acc_reg | ({56'd0, bsel} << {bpos_reg, 3'd0});
                bpos_next = bpos_reg + 3'd1;
            end
        end
        if (cmd.start_accept || cmd.group_close) begin
            held_next = 6'd0; bpos_next = 3'd0;
        end
    end
    always_ff @(posedge aclk) if (wr_en) acc_reg <= wr_data;

    fpr_ram #(.WIDTH(64), .DEPTH(fpr_pkg::STORE_DEPTH)) u_store (
        .clk(aclk), .wr_en(wr_en), .wr_addr(wr_addr[4:0]), .wr_data(wr_data),
        .rd_addr(idx_reg[4:0] + (cmd.idx_step ? 5'd1 : 5'd0)), .rd_data(word_rd)
    );
    assign sts.pack_done = !cmd.out_load ? (idx_reg + LW'(1) >= n_reg) :
                           (idx_reg + LW'(1) >= LW'(held_reg));

    // Counters, group state and link mode
    logic [15:0] cnt_inc;
    logic [4:0] grp_inc;
    logic [4:0] rew;
    logic [15:0] count_rewound;
    logic rewound_done;
    assign cnt_inc = count_reg + 16'd1;
    // Restart the group position when the group fills or the count wraps to zero
    assign grp_inc = ((cnt_inc == 16'd0) || (grp_reg + 5'd1 >= g)) ? 5'd0 : grp_reg + 5'd1;
    // Rewind to the start of the current group, never below zero
    assign rew = (grp_reg == 5'd0) ? g : grp_reg;
    assign count_rewound = (count_reg >= 16'(rew)) ? count_reg - 16'(rew) : 16'd0;
    assign rewound_done  = group_ok_reg ? (count_reg == total_reg) :
                                          (count_rewound == total_reg);
    always_comb begin
        count_next = count_reg; group_ok_next = group_ok_reg;
        grp_next = grp_reg; mode_next = mode_reg; len_next = len_reg;
        if (cmd.connect) begin mode_next = fpr_pkg::MODE_CONNECTED; len_next = '0; end
        if (cmd.drop_byte) len_next = '0;
        if (cmd.load_byte) len_next = in_last_byte ? '0 :
                                      (len_reg <= MAXL ? len_reg + LW'(1) : len_reg);
        if (cmd.start_accept) begin
            count_next = '0; group_ok_next = 1'b1; grp_next = '0;
            mode_next = fpr_pkg::MODE_RECEIVING;
        end
        if (cmd.write_check && !sts.write_ok) group_ok_next = 1'b0;
        if (cmd.count_bump) begin count_next = cnt_inc; grp_next = grp_inc; end
        if (cmd.group_close) begin
            if (!group_ok_reg)
                count_next = count_rewound;
            grp_next = '0; group_ok_next = 1'b1;
            if (rewound_done) mode_next = fpr_pkg::MODE_CLOSING;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= fpr_pkg::MODE_IDLE; len_reg <= '0; total_reg <= '0;
            count_reg <= '0; group_ok_reg <= 1'b1; held_reg <= '0;
            bpos_reg <= '0; grp_reg <= '0; n_reg <= '0;
        end else begin
            mode_reg <= mode_next; len_reg <= len_next; count_reg <= count_next;
            group_ok_reg <= group_ok_next; held_reg <= held_next;
            bpos_reg <= bpos_next; grp_reg <= grp_next;
            if (cmd.load_byte && in_last_byte)
                n_reg <= (len_reg <= MAXL) ? len_reg + LW'(1) : len_reg;
            if (cmd.start_accept) total_reg <= {buf_reg[1], buf_reg[2]};
        end
    end

    // Group close decision on the advanced count
    assign sts.group_due  = (grp_inc == 5'd0) || (cnt_inc == total_reg);
    assign sts.group_good = group_ok_reg;
    assign sts.done_after = rewound_done;
    assign sts.words_held = held_reg;
    assign sts.is_last    = in_last_byte;
    assign sts.active     = (mode_reg == fpr_pkg::MODE_CONNECTED) ||
                            (mode_reg == fpr_pkg::MODE_RECEIVING);
    assign sts.receiving  = (mode_reg == fpr_pkg::MODE_RECEIVING);

    // Acknowledgement byte select; a start packet is good once receiving
    always_comb begin
        unique case (ack_pos)
            3'd0: ack_byte = (out_from_start ? (mode_reg != fpr_pkg::MODE_RECEIVING)
                                             : !group_ok_reg)
                             ? fpr_pkg::ACK_BAD : 8'h00;
            3'd1: ack_byte = 8'h00;
            3'd2: ack_byte = hi;
            3'd3: ack_byte = lo;
            default: ack_byte = hi + lo;
        endcase
    end

    // Output register
    assign out_free = !m_valid_reg || m_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (cmd.out_load) m_valid_reg <= 1'b1;
        else if (m_ready) m_valid_reg <= 1'b0;
    end
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_kind_reg <= out_kind_in;
            m_last_reg <= out_last_in;
            m_done_reg <= !out_from_start && rewound_done;
            unique case (out_kind_in)
                fpr_pkg::KIND_FLASH: begin
                    m_value_reg <= word_rd; m_word_reg <= idx_reg[4:0];
                end
                fpr_pkg::KIND_ACK: begin
                    m_value_reg <= {56'd0, ack_byte}; m_word_reg <= 5'd0;
                end
                default: begin m_value_reg <= '0; m_word_reg <= 5'd0; end
            endcase
        end
    end
    assign m_valid = m_valid_reg;
    assign m_kind = m_kind_reg;
    assign m_value = m_value_reg;
    assign m_word_number = m_word_reg;
    assign m_transfer_done = m_done_reg;
    assign m_last_of_run = m_last_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/fpr_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
`default_nettype none
module fpr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    // Write and registered read; a read of the address being written returns the old word
    always_ff @(posedge clk) begin
        if (wr_en) mem_reg[wr_addr] <= wr_data;
        rd_data <= mem_reg[rd_addr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/firmware_packet_receiver_top.sv
// Firmware packet receiver top level.
// A connect event or a byte that ends no packet is taken in the idle state. A packet end runs
// the checksum walk over the packet buffer and a decision step; a good write then unpacks its
// payload and every write advances the count. Then one result per cycle (erase, 5 ack bytes,
// up to 32 flash words) paced by m_ready, and a finish step closes a group.
// One item at a time. Synchronous active-low reset clears all control state.
`default_nettype none
module firmware_packet_receiver_top #(
    parameter int PACKET_MAX_BYTES = 20,
    parameter int PAYLOAD_BYTES    = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [63:0]      m_value,
    output logic [4:0]       m_word_number,
    output logic             m_transfer_done,
    output logic             m_last_of_run
);
    fpr_pkg::ctrl_cmd_t    cmd;
    fpr_pkg::ctrl_status_t sts;
    fpr_pkg::result_kind_t out_kind;
    logic [2:0] ack_pos;
    logic out_last, out_from_start, out_free;

    fpr_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .in_operation(s_operation), .out_free(out_free), .sts(sts), .cmd(cmd),
        .out_kind(out_kind), .ack_pos(ack_pos), .out_last(out_last),
        .out_from_start(out_from_start)
    );

    fpr_datapath #(.PACKET_MAX_BYTES(PACKET_MAX_BYTES), .PAYLOAD_BYTES(PAYLOAD_BYTES))
    u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_data_byte(s_data_byte), .in_last_byte(s_last_byte),
        .cmd(cmd), .out_kind_in(out_kind), .ack_pos(ack_pos), .out_last_in(out_last),
        .out_from_start(out_from_start), .sts(sts), .out_free(out_free),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind), .m_value(m_value),
        .m_word_number(m_word_number), .m_transfer_done(m_transfer_done),
        .m_last_of_run(m_last_of_run)
    );

    // A result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free) else $error("result overwritten");
    // Input is not taken while results are being produced
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !s_ready) else $error("input accepted during output");
    // Ack and erase carry word number zero
    a_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != fpr_pkg::KIND_FLASH) |-> m_word_number == 5'd0)
        else $error("word number on non-flash result");
endmodule
`default_nettype wire

FILE: tb/tb_firmware_packet_receiver_top.sv
// Self-checking testbench for the firmware packet receiver top level.
// Depends on fpr_pkg and firmware_packet_receiver_top; a scoreboard class predicts each result.
// Stimulus mixes directed packets with random start and write transfers under several settings.
`default_nettype none

module tb_firmware_packet_receiver_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PKT_MAX     = 20;
    localparam int PAYLOAD_MAX = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 80;

    typedef bit [7:0] byte_q_t[$];

    typedef struct {
        fpr_pkg::result_kind_t kind;
        bit [63:0]    value;
        bit [4:0]     word;
        bit           done;
        bit           last;
    } result_t;

    // Scoreboard: mirrors the receiver state and holds the results still owed
    class packet_scoreboard;
        bit [7:0]    start_cmd;
        bit [4:0]    start_len;
        bit [7:0]    write_cmd;
        bit [4:0]    group;
        fpr_pkg::link_mode_t mode;
        bit [7:0]    pkt[PKT_MAX];
        int unsigned plen;
        bit [15:0]   total;
        bit [15:0]   count;
        bit          group_ok;
        bit [63:0]   words[fpr_pkg::STORE_DEPTH];
        int unsigned held;
        int unsigned bpos;
        result_t     run[$];
        result_t     owed[$];
        int unsigned errors;
        int unsigned checked;

        function new();
            start_cmd = 8'h00;
            start_len = 5'd4;
            write_cmd = 8'h01;
            group     = 5'd16;
            mode      = fpr_pkg::MODE_IDLE;
            plen      = 0;
            total     = '0;
            count     = '0;
            group_ok  = 1'b1;
            held      = 0;
            bpos      = 0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void set_reg(fpr_pkg::reg_index_t idx, bit [7:0] v);
            case (idx)
                fpr_pkg::REG_START_COMMAND: start_cmd = v;
                fpr_pkg::REG_START_LENGTH:  start_len = v[4:0];
                fpr_pkg::REG_WRITE_COMMAND: write_cmd = v;
                fpr_pkg::REG_ACK_GROUP:     group = v[4:0];
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        function void push(fpr_pkg::result_kind_t kind, bit [63:0] value, bit [4:0] word);
            result_t r;
            r.kind  = kind;
            r.value = value;
            r.word  = word;
            r.done  = 1'b0;
            r.last  = 1'b0;
            run.push_back(r);
        endfunction

        function void push_ack(bit good);
            bit [7:0] hi, lo;
            hi = count[15:8];
            lo = count[7:0];
            push(fpr_pkg::KIND_ACK, good ? 64'h0 : 64'(fpr_pkg::ACK_BAD), 0);
            push(fpr_pkg::KIND_ACK, 64'h0, 0);
            push(fpr_pkg::KIND_ACK, 64'(hi), 0);
            push(fpr_pkg::KIND_ACK, 64'(lo), 0);
            push(fpr_pkg::KIND_ACK, 64'(8'(hi + lo)), 0);
        endfunction

        function bit [7:0] byte_sum(int unsigned first, int unsigned last);
            bit [7:0] s;
            s = 8'h00;
            for (int unsigned i = first; i <= last && i < PKT_MAX; i++)
                s += pkt[i];
            return s;
        endfunction

        function void pack_byte(bit [7:0] b);
            if (bpos == 0) begin
                if (held >= fpr_pkg::STORE_DEPTH)
                    return;
                words[held] = 64'(b);
                held++;
            end else begin
                words[held-1] |= 64'(b) << (bpos * 8);
            end
            bpos = (bpos + 1) % 8;
        endfunction

        function void close_start(int unsigned n);
            bit ok;
            ok = n >= 4 && n <= PKT_MAX && n == start_len && pkt[0] == start_cmd &&
                 byte_sum(1, n - 2) == pkt[n-1];
            if (ok) begin
                total    = {pkt[1], pkt[2]};
                count    = '0;
                held     = 0;
                bpos     = 0;
                group_ok = 1'b1;
                push(fpr_pkg::KIND_ERASE, 64'h0, 0);
                push_ack(1'b1);
                mode = fpr_pkg::MODE_RECEIVING;
            end else begin
                push_ack(1'b0);
            end
        endfunction

        function void close_write(int unsigned n);
            int unsigned g, r;
            bit ok;
            g  = (group == 0) ? 1 : group;
            ok = n >= 4 && n <= PKT_MAX && n - 4 <= PAYLOAD_MAX && pkt[0] == write_cmd &&
                 byte_sum(3, n - 2) == pkt[n-1];
            if (ok && {pkt[1], pkt[2]} == count) begin
                for (int unsigned i = 3; i + 1 < n; i++)
                    pack_byte(pkt[i]);
            end else begin
                group_ok = 1'b0;
            end
            count++;
            if (count % g == 0 || count == total) begin
                push_ack(group_ok);
                if (!group_ok) begin
                    r = count % g;
                    if (r == 0)
                        r = g;
                    count = (count >= r) ? 16'(count - r) : 16'h0;
                end else begin
                    for (int unsigned i = 0; i < held; i++)
                        push(fpr_pkg::KIND_FLASH, words[i], 5'(i));
                end
                if (count == total) begin
                    mode = fpr_pkg::MODE_CLOSING;
                    foreach (run[j])
                        run[j].done = 1'b1;
                end
                held     = 0;
                bpos     = 0;
                group_ok = 1'b1;
            end
        endfunction

        // Note one accepted input transaction and queue the results it causes
        function void note_input(bit op, bit [7:0] b, bit last);
            int unsigned n;
            run.delete();
            if (!op) begin
                mode = fpr_pkg::MODE_CONNECTED;
                plen = 0;
                return;
            end
            if (mode != fpr_pkg::MODE_CONNECTED && mode != fpr_pkg::MODE_RECEIVING) begin
                plen = 0;
                return;
            end
            if (plen < PKT_MAX)
                pkt[plen] = b;
            if (plen <= PKT_MAX)
                plen++;
            if (!last)
                return;
            n    = plen;
            plen = 0;
            if (mode == fpr_pkg::MODE_CONNECTED)
                close_start(n);
            else
                close_write(n);
            if (run.size() > 0)
                run[run.size()-1].last = 1'b1;
            foreach (run[j])
                owed.push_back(run[j]);
        endfunction

        // Compare one accepted result with the oldest one owed
        task check_result(result_t got);
            result_t want;
            checked++;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result kind %0d value %0h", got.kind, got.value));
                return;
            end
            want = owed.pop_front();
            if (got.kind != want.kind)
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.value != want.value)
                report($sformatf("value %0h, want %0h", got.value, want.value));
            if (got.word != want.word)
                report($sformatf("word_number %0d, want %0d", got.word, want.word));
            if (got.done != want.done)
                report($sformatf("transfer_done %0b, want %0b", got.done, want.done));
            if (got.last != want.last)
                report($sformatf("last_of_run %0b, want %0b", got.last, want.last));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = 1'b0;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [63:0] m_value;
    logic [4:0]  m_word_number;
    logic        m_transfer_done;
    logic        m_last_of_run;

    packet_scoreboard sb = new();
    int unsigned items = 0;
    int unsigned item_goal = 0;
    int unsigned cycles = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    bit          hold_off = 1'b0;

    firmware_packet_receiver_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_value         (m_value),
        .m_word_number   (m_word_number),
        .m_transfer_done (m_transfer_done),
        .m_last_of_run   (m_last_of_run)
    );

    always #6 aclk = ~aclk;

    // Abort on a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off entirely during the pressure stretch
    always @(posedge aclk) begin
        m_ready <= hold_off ? 1'b0 : ($urandom_range(99) >= stall_pct);
    end

    // Sample results between edges, where both sides are settled
    always @(negedge aclk) begin
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.kind  = fpr_pkg::result_kind_t'(m_kind);
            got.value = m_value;
            got.word  = m_word_number;
            got.done  = m_transfer_done;
            got.last  = m_last_of_run;
            sb.check_result(got);
        end
    end

    task automatic send_item(input bit op, input bit [7:0] b, input bit last);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_data_byte <= b;
        s_last_byte <= last;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
        sb.note_input(op, b, last);
        items++;
    endtask

    task automatic send_packet(input byte_q_t p);
        foreach (p[i])
            send_item(1'b1, p[i], i == p.size() - 1);
    endtask

    // Start packet; flaw 0 none, 1 checksum, 2 command, 3 length, 4 short
    function automatic byte_q_t make_start(bit [15:0] tot, int flaw);
        byte_q_t p;
        int unsigned n;
        bit [7:0] s;
        n = (sb.start_len < 4) ? 4 : sb.start_len;
        if (flaw == 3)
            n++;
        p = '{sb.start_cmd, tot[15:8], tot[7:0]};
        while (p.size() < n - 1)
            p.push_back(8'($urandom));
        s = 8'h00;
        for (int i = 1; i < p.size(); i++)
            s += p[i];
        p.push_back(s);
        if (flaw == 1)
            p[n-1] = p[n-1] + 8'd1;
        if (flaw == 2)
            p[0] = p[0] + 8'd1;
        if (flaw == 4)
            p = '{p[0], p[1]};
        return p;
    endfunction

    // Write packet; flaw 0 none, 1 checksum, 2 command, 3 sequence, 4 short, 5 overlong
    function automatic byte_q_t make_write(int unsigned plen, int flaw);
        byte_q_t p;
        bit [15:0] seq;
        bit [7:0] s;
        seq = sb.count;
        if (flaw == 3)
            seq = seq + 16'($urandom_range(1, 3));
        if (flaw == 5)
            plen = $urandom_range(PAYLOAD_MAX + 1, PAYLOAD_MAX + 6);
        p = '{sb.write_cmd, seq[15:8], seq[7:0]};
        s = 8'h00;
        repeat (plen) begin
            p.push_back(8'($urandom));
            s += p[p.size()-1];
        end
        p.push_back(s);
        if (flaw == 1)
            p[p.size()-1] = s ^ 8'h80;
        if (flaw == 2)
            p[0] = ~p[0];
        if (flaw == 4)
            p = p[0:$urandom_range(0, 2)];
        return p;
    endfunction

    // One transfer: connect, start handshake, then writes until closed or capped
    task automatic run_transfer();
        int unsigned pk;
        bit [15:0] tot;
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 5))
                send_item(1'b1, 8'($urandom), 1'b0);
        send_item(1'b0, 8'($urandom), 1'($urandom));
        if ($urandom_range(9) == 0) begin
            byte_q_t noise;
            repeat ($urandom_range(1, 24))
                noise.push_back(8'($urandom));
            send_packet(noise);
        end
        for (int tries = 0; tries < 3 && sb.mode != fpr_pkg::MODE_RECEIVING; tries++) begin
            tot = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10));
            send_packet(make_start(tot, ($urandom_range(5) == 0) ? $urandom_range(1, 4) : 0));
        end
        pk = 0;
        while (sb.mode == fpr_pkg::MODE_RECEIVING && pk < 40 && items < item_goal + 24) begin
            send_packet(make_write(($urandom_range(3) == 0) ? PAYLOAD_MAX :
                                   $urandom_range(0, PAYLOAD_MAX),
                                   ($urandom_range(9) == 0) ? $urandom_range(1, 5) : 0));
            pk++;
        end
        // Bytes after the transfer has closed are dropped
        if (sb.mode == fpr_pkg::MODE_CLOSING && $urandom_range(2) == 0)
            send_item(1'b1, 8'($urandom), 1'b1);
    endtask

    // Let every owed result arrive, then allow for packet-end work still in flight
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input fpr_pkg::reg_index_t idx, input bit [7:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        sb.set_reg(idx, v);
    endtask

    task automatic configure(input int p);
        case (p)
            1: begin
                write_reg(fpr_pkg::REG_START_COMMAND, 8'hff);
                write_reg(fpr_pkg::REG_START_LENGTH, 8'd20);
                write_reg(fpr_pkg::REG_WRITE_COMMAND, 8'h00);
                write_reg(fpr_pkg::REG_ACK_GROUP, 8'd1);
            end
            2: begin
                write_reg(fpr_pkg::REG_START_COMMAND, 8'h5a);
                write_reg(fpr_pkg::REG_START_LENGTH, 8'd4);
                write_reg(fpr_pkg::REG_WRITE_COMMAND, 8'hff);
                write_reg(fpr_pkg::REG_ACK_GROUP, 8'd0);
            end
            3: begin
                write_reg(fpr_pkg::REG_START_COMMAND, 8'($urandom));
                write_reg(fpr_pkg::REG_START_LENGTH, 8'($urandom_range(4, 20)));
                write_reg(fpr_pkg::REG_WRITE_COMMAND, 8'($urandom));
                write_reg(fpr_pkg::REG_ACK_GROUP, 8'd31);
            end
            default: begin
                write_reg(fpr_pkg::REG_START_COMMAND, 8'($urandom));
                write_reg(fpr_pkg::REG_START_LENGTH, ($urandom_range(7) == 0) ?
                          8'($urandom_range(0, 31)) : 8'($urandom_range(4, 20)));
                write_reg(fpr_pkg::REG_WRITE_COMMAND, 8'($urandom));
                write_reg(fpr_pkg::REG_ACK_GROUP, ($urandom_range(5) == 0) ?
                          8'($urandom_range(0, 31)) : 8'($urandom_range(1, 16)));
            end
        endcase
        cfg_write <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle byte, connect, short and good start, empty write, bad sequence
        send_item(1'b1, 8'hff, 1'b1);
        send_item(1'b0, 8'h00, 1'b0);
        send_packet(make_start(16'd2, 4));
        send_packet(make_start(16'd2, 0));
        send_packet(make_write(0, 0));
        send_packet(make_write(PAYLOAD_MAX, 3));

        for (int p = 0; p < 8; p++) begin
            drain();
            if (p > 0)
                configure(p);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            // Hold the receiver off long enough for the input to back up
            if (p == 2)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            item_goal = 60 * (p + 1);
            while (items < item_goal)
                run_transfer();
        end
        drain();

        $display("Run covered %0d input transactions and %0d checked results", items, sb.checked);
        $display("over eight register settings with sender gaps and receiver stalls");
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/fpr_pkg.sv
hw/rtl/fpr_ctrl.sv
hw/rtl/fpr_datapath.sv
hw/rtl/fpr_ram.sv
hw/rtl/firmware_packet_receiver_top.sv
tb/tb_firmware_packet_receiver_top.sv
